// ===== sv/lcps_pkg.sv =====
package lcps_pkg;

  // Field widths
  localparam int LEN_W   = 14;
  localparam int KERF_W  = 10;
  localparam int STOCK_W = 3;

  // Default list sizes
  localparam int DEF_MAX_PARTS = 16;
  localparam int DEF_MAX_STOCK = 8;

  // Remnant value meaning "no candidate yet"
  localparam logic [LEN_W-1:0] NO_REMNANT = 14'd10000;

  // Action codes
  localparam logic [1:0] ACT_ADD_PART  = 2'd0;
  localparam logic [1:0] ACT_ADD_STOCK = 2'd1;
  localparam logic [1:0] ACT_PLAN      = 2'd2;
  localparam logic [1:0] ACT_CLEAR     = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_PLACED   = 2'd0;
  localparam logic [1:0] KIND_UNPLACED = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic add_part;
    logic add_stock;
    logic clear_job;
    logic plan_init;
    logic round_init;
    logic walk_init;
    logic walk_step;
    logic stock_end;
    logic next_stock;
    logic round_commit;
    logic rep_init;
    logic rep_placed_step;
    logic rep_free_init;
    logic rep_free_step;
    logic rep_end;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic round_over;
    logic stock_over;
    logic stock_taken_cur;
    logic walk_done;
    logic free_over;
  } status_t;

endpackage

// ===== sv/lcps_ctrl.sv =====
module lcps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       action,
  input  lcps_pkg::status_t status,
  output lcps_pkg::cmd_t   cmd,
  output logic             busy
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_ROUND      = 3'd1;
  localparam logic [2:0] S_STOCK      = 3'd2;
  localparam logic [2:0] S_WALK       = 3'd3;
  localparam logic [2:0] S_REP_PLACED = 3'd4;
  localparam logic [2:0] S_REP_FREE   = 3'd5;
  localparam logic [2:0] S_REP_END    = 3'd6;

  logic [2:0] state, state_next;

  assign busy = (state != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load and clear decode, sequencing of rounds, stock searches and report
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (action)
            lcps_pkg::ACT_ADD_PART:  cmd.add_part  = 1'b1;
            lcps_pkg::ACT_ADD_STOCK: cmd.add_stock = 1'b1;
            lcps_pkg::ACT_CLEAR:     cmd.clear_job = 1'b1;
            lcps_pkg::ACT_PLAN: begin
              cmd.plan_init = 1'b1;
              state_next    = S_ROUND;
            end
            default: ;
          endcase
        end
      end
      S_ROUND: begin
        if (status.round_over) begin
          cmd.rep_init = 1'b1;
          state_next   = S_REP_PLACED;
        end else begin
          cmd.round_init = 1'b1;
          state_next     = S_STOCK;
        end
      end
      S_STOCK: begin
        if (status.stock_over) begin
          cmd.round_commit = 1'b1;
          state_next       = S_ROUND;
        end else if (status.stock_taken_cur) begin
          cmd.next_stock = 1'b1;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_WALK;
        end
      end
      S_WALK: begin
        if (status.walk_done) begin
          cmd.stock_end  = 1'b1;
          cmd.next_stock = 1'b1;
          state_next     = S_STOCK;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_REP_PLACED: begin
        if (status.stock_over) begin
          cmd.rep_free_init = 1'b1;
          state_next        = S_REP_FREE;
        end else begin
          cmd.rep_placed_step = 1'b1;
        end
      end
      S_REP_FREE: begin
        if (status.free_over) begin
          state_next = S_REP_END;
        end else begin
          cmd.rep_free_step = 1'b1;
        end
      end
      S_REP_END: begin
        cmd.rep_end = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/lcps_datapath.sv =====
module lcps_datapath #(
  parameter int MAX_PARTS = lcps_pkg::DEF_MAX_PARTS,
  parameter int MAX_STOCK = lcps_pkg::DEF_MAX_STOCK
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lcps_pkg::cmd_t              cmd,
  output lcps_pkg::status_t           status,
  input  logic [lcps_pkg::LEN_W-1:0]  length_value,
  input  logic                        cfg_valid,
  input  logic [lcps_pkg::KERF_W-1:0] cfg_data,
  output logic                        result_valid,
  output logic [1:0]                  kind,
  output logic [lcps_pkg::STOCK_W-1:0] stock_number,
  output logic [lcps_pkg::LEN_W-1:0]  part_length,
  output logic [lcps_pkg::LEN_W-1:0]  end_offset,
  output logic                        last
);

  localparam int LW  = lcps_pkg::LEN_W;
  localparam int PW  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int PW1 = $clog2(MAX_PARTS + 1);
  localparam int SW  = (MAX_STOCK > 1) ? $clog2(MAX_STOCK) : 1;
  localparam int SW1 = $clog2(MAX_STOCK + 1);
  localparam int NW  = LW + 3;

  // Job storage
  logic [lcps_pkg::KERF_W-1:0] kerf;
  logic [LW-1:0]        part_len [MAX_PARTS];
  logic [LW-1:0]        stock_len [MAX_STOCK];
  logic [PW1-1:0]       part_total;
  logic [SW1-1:0]       stock_total;
  logic [MAX_PARTS-1:0] placed;
  logic [MAX_STOCK-1:0] taken;
  logic [MAX_PARTS-1:0] assign_mask [MAX_STOCK];

  // Subset walk
  logic [LW-1:0]        sum_stack [MAX_PARTS];
  logic [SW1-1:0]       s;
  logic [PW1-1:0]       i;
  logic [PW1-1:0]       count;
  logic [LW-1:0]        sum;
  logic [MAX_PARTS-1:0] mask;
  logic [LW-1:0]        crem;
  logic [PW1-1:0]       ccount;
  logic [MAX_PARTS-1:0] cmask;

  // Round selection
  logic [LW-1:0]        best_rem;
  logic [SW-1:0]        best_s;
  logic [MAX_PARTS-1:0] best_mask;
  logic                 found;
  logic [SW1-1:0]       round;

  // Report
  logic [LW-1:0]        off;
  logic                 first;

  // Walk arithmetic
  logic [LW-1:0]        cur_len;
  logic [LW-1:0]        cap;
  logic [NW-1:0]        need;
  logic                 fits;
  logic [LW-1:0]        rem;
  logic [PW1-1:0]       count_inc;
  logic                 better;
  logic [PW-1:0]        top;
  logic [MAX_PARTS-1:0] valid_parts;
  logic [LW-1:0]        off_new;

  assign cur_len   = part_len[i[PW-1:0]];
  assign cap       = stock_len[s[SW-1:0]];
  assign need      = (count == '0) ? NW'(cur_len)
                   : NW'(sum) + NW'(kerf) + NW'(cur_len);
  assign fits      = !placed[i[PW-1:0]] && (need <= NW'(cap));
  assign rem       = cap - need[LW-1:0];
  assign count_inc = count + PW1'(1);
  assign better    = (rem < crem) || ((rem == crem) && (count_inc < ccount));
  assign off_new   = (first ? '0 : off + LW'(kerf)) + cur_len;

  // Highest set bit of the walk mask: most recently added part
  always_comb begin
    top = '0;
    for (int k = 0; k < MAX_PARTS; k++) begin
      if (mask[k]) top = PW'(k);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PARTS; k++) begin
      valid_parts[k] = (PW1'(k) < part_total);
    end
  end

  // Status to the controller
  always_comb begin
    status.round_over      = (round == stock_total) ||
                             ((placed | ~valid_parts) == '1);
    status.stock_over      = (s == stock_total);
    status.stock_taken_cur = taken[s[SW-1:0]];
    status.walk_done       = (i >= part_total) && (count == '0);
    status.free_over       = (i == part_total);
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      kerf <= '0;
    end else if (cfg_valid) begin
      kerf <= cfg_data;
    end
  end

  // List storage, no reset
  always_ff @(posedge clk) begin
    if (cmd.add_part && part_total < PW1'(MAX_PARTS)) begin
      part_len[part_total[PW-1:0]] <= length_value;
    end
    if (cmd.add_stock && stock_total < SW1'(MAX_STOCK)) begin
      stock_len[stock_total[SW-1:0]] <= length_value;
    end
    if (cmd.walk_step && i < part_total && fits) begin
      sum_stack[count[PW-1:0]] <= sum;
    end
  end

  // Plan control state
  always_ff @(posedge clk) begin
    if (rst) begin
      part_total  <= '0;
      stock_total <= '0;
      placed      <= '0;
      taken       <= '0;
      round       <= '0;
      for (int k = 0; k < MAX_STOCK; k++) assign_mask[k] <= '0;
    end else begin
      if (cmd.add_part && part_total < PW1'(MAX_PARTS)) begin
        part_total <= part_total + PW1'(1);
      end
      if (cmd.add_stock && stock_total < SW1'(MAX_STOCK)) begin
        stock_total <= stock_total + SW1'(1);
      end
      if (cmd.clear_job) begin
        part_total  <= '0;
        stock_total <= '0;
      end
      if (cmd.clear_job || cmd.plan_init) begin
        placed <= '0;
        taken  <= '0;
        round  <= '0;
        for (int k = 0; k < MAX_STOCK; k++) assign_mask[k] <= '0;
      end
      if (cmd.round_commit) begin
        round <= round + SW1'(1);
        if (found) begin
          taken[best_s]       <= 1'b1;
          assign_mask[best_s] <= best_mask;
          placed              <= placed | best_mask;
        end
      end
    end
  end

  // Walk, selection and report registers
  always_ff @(posedge clk) begin
    if (cmd.round_init) begin
      s        <= '0;
      best_rem <= lcps_pkg::NO_REMNANT;
      found    <= 1'b0;
    end
    if (cmd.walk_init) begin
      i      <= '0;
      count  <= '0;
      sum    <= '0;
      mask   <= '0;
      crem   <= lcps_pkg::NO_REMNANT;
      ccount <= '0;
      cmask  <= '0;
    end
    if (cmd.walk_step) begin
      if (i < part_total) begin
        i <= i + PW1'(1);
        if (fits) begin
          sum                  <= need[LW-1:0];
          mask[i[PW-1:0]]      <= 1'b1;
          count                <= count_inc;
          if (better) begin
            crem   <= rem;
            ccount <= count_inc;
            cmask  <= mask | (MAX_PARTS'(1) << i[PW-1:0]);
          end
        end
      end else begin
        // backtrack: drop the last part added
        mask[top] <= 1'b0;
        count     <= count - PW1'(1);
        sum       <= sum_stack[PW'(count - PW1'(1))];
        i         <= PW1'(top) + PW1'(1);
      end
    end
    if (cmd.stock_end && ccount != '0 && crem < best_rem) begin
      best_rem  <= crem;
      best_s    <= s[SW-1:0];
      best_mask <= cmask;
      found     <= 1'b1;
    end
    if (cmd.next_stock && !cmd.rep_placed_step) begin
      s <= s + SW1'(1);
    end
    if (cmd.rep_init) begin
      s     <= '0;
      i     <= '0;
      off   <= '0;
      first <= 1'b1;
    end
    if (cmd.rep_placed_step) begin
      if (!taken[s[SW-1:0]] || i == part_total) begin
        s     <= s + SW1'(1);
        i     <= '0;
        off   <= '0;
        first <= 1'b1;
      end else begin
        i <= i + PW1'(1);
        if (assign_mask[s[SW-1:0]][i[PW-1:0]]) begin
          off   <= off_new;
          first <= 1'b0;
        end
      end
    end
    if (cmd.rep_free_init) begin
      i <= '0;
    end
    if (cmd.rep_free_step) begin
      i <= i + PW1'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.rep_placed_step && taken[s[SW-1:0]] && i != part_total &&
                       assign_mask[s[SW-1:0]][i[PW-1:0]]) ||
                      (cmd.rep_free_step && !placed[i[PW-1:0]]) ||
                      cmd.rep_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_placed_step) begin
      kind         <= lcps_pkg::KIND_PLACED;
      stock_number <= lcps_pkg::STOCK_W'(s);
      part_length  <= cur_len;
      end_offset   <= off_new;
      last         <= 1'b0;
    end else if (cmd.rep_free_step) begin
      kind         <= lcps_pkg::KIND_UNPLACED;
      stock_number <= '0;
      part_length  <= cur_len;
      end_offset   <= '0;
      last         <= 1'b0;
    end else if (cmd.rep_end) begin
      kind         <= lcps_pkg::KIND_END;
      stock_number <= '0;
      part_length  <= '0;
      end_offset   <= '0;
      last         <= 1'b1;
    end
  end

endmodule

// ===== sv/linear_cut_plan_search.sv =====
// Cutting-stock planner. Part and stock lengths load one per start, each
// with no result, and so does clear. A plan start keeps busy high while it
// runs rounds: in each round every untaken stock is searched by a
// depth-first subset walk that tries or backtracks one part per cycle, so
// the plan time grows with the number of subsets that fit. The report then
// scans stocks and parts one position per cycle. Results appear on
// result_valid for exactly one cycle each and cannot be stalled; the
// end-of-report item shows in the first cycle that busy is low. Kerf is to
// be written over cfg only while idle, which the block does not enforce;
// cfg_ready is always high.
module linear_cut_plan_search #(
  parameter int MAX_PARTS = lcps_pkg::DEF_MAX_PARTS,
  parameter int MAX_STOCK = lcps_pkg::DEF_MAX_STOCK
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [lcps_pkg::LEN_W-1:0]   length_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lcps_pkg::KERF_W-1:0]  cfg_data,
  output logic                         result_valid,
  output logic [1:0]                   kind,
  output logic [lcps_pkg::STOCK_W-1:0] stock_number,
  output logic [lcps_pkg::LEN_W-1:0]   part_length,
  output logic [lcps_pkg::LEN_W-1:0]   end_offset,
  output logic                         last
);

  lcps_pkg::cmd_t    cmd;
  lcps_pkg::status_t status;

  assign cfg_ready = 1'b1;

  lcps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lcps_datapath #(
    .MAX_PARTS (MAX_PARTS),
    .MAX_STOCK (MAX_STOCK)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .length_value (length_value),
    .cfg_valid    (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .kind         (kind),
    .stock_number (stock_number),
    .part_length  (part_length),
    .end_offset   (end_offset),
    .last         (last)
  );

endmodule

// ===== sv/lcps_checker.sv =====
module lcps_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] action,
  input logic       result_valid,
  input logic [1:0] kind,
  input logic       last
);

  // last marks the end item and only it
  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> kind == lcps_pkg::KIND_END)
    else $error("last on non-end item");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == lcps_pkg::KIND_END |-> last)
    else $error("end item without last");

  // load and clear transfers give no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action != lcps_pkg::ACT_PLAN |=> !result_valid)
    else $error("result after load or clear");

  // after reset the block is idle and quiet
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !busy)
    else $error("activity after reset");

endmodule

bind linear_cut_plan_search lcps_checker u_lcps_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .result_valid (result_valid),
  .kind         (kind),
  .last         (last)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int NPARTS = lcps_pkg::DEF_MAX_PARTS;
  localparam int NSTOCK = lcps_pkg::DEF_MAX_STOCK;
  localparam int GOAL_ITEMS = 320;
  localparam int LW = lcps_pkg::LEN_W;
  localparam int KW = lcps_pkg::KERF_W;
  localparam int STW = lcps_pkg::STOCK_W;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] action;
  logic [LW-1:0] length_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [KW-1:0] cfg_data;
  logic result_valid;
  logic [1:0] kind;
  logic [STW-1:0] stock_number;
  logic [LW-1:0] part_length;
  logic [LW-1:0] end_offset;
  logic last;

  linear_cut_plan_search u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .length_value(length_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .kind(kind),
    .stock_number(stock_number),
    .part_length(part_length),
    .end_offset(end_offset),
    .last(last)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  typedef struct {
    logic [1:0] kind;
    logic [STW-1:0] stock;
    logic [LW-1:0] plen;
    logic [LW-1:0] offset;
    logic fin;
  } cut_line_t;

  cut_line_t report_q[$];
  int mismatches = 0;
  int sent_items = 0;

  // Planner shadow state
  int unsigned kerf;
  int unsigned part_len[NPARTS];
  bit part_done[NPARTS];
  int unsigned part_cnt;
  int unsigned stock_len[NSTOCK];
  bit stock_used[NSTOCK];
  int unsigned stock_cnt;
  int unsigned stock_parts[NSTOCK];
  int unsigned best_set[NSTOCK];
  int unsigned best_rem[NSTOCK];
  int unsigned best_num[NSTOCK];
  int unsigned cur_set;
  int unsigned cur_sum;
  int unsigned cur_num;

  // Depth-first subset walk, parts added in ascending index order
  function automatic void fit_walk(int unsigned s, int unsigned first);
    int unsigned need;
    int unsigned rem;
    int unsigned saved;
    for (int unsigned i = first; i < part_cnt; i++) begin
      if (part_done[i]) continue;
      need = (cur_num == 0) ? part_len[i] : cur_sum + kerf + part_len[i];
      if (need > stock_len[s]) continue;
      saved = cur_sum;
      cur_sum = need;
      cur_set |= 1 << i;
      cur_num++;
      rem = stock_len[s] - cur_sum;
      if (rem < best_rem[s] || (rem == best_rem[s] && cur_num < best_num[s])) begin
        best_rem[s] = rem;
        best_num[s] = cur_num;
        best_set[s] = cur_set;
      end
      fit_walk(s, i + 1);
      cur_num--;
      cur_set &= ~(1 << i);
      cur_sum = saved;
    end
  endfunction

  // Full plan followed by the report lines it produces
  function automatic void plan_cuts();
    int unsigned win_rem;
    int unsigned win;
    bit found;
    bit all_done;
    int unsigned off;
    int unsigned n;
    cut_line_t line;
    for (int s = 0; s < NSTOCK; s++) begin
      stock_used[s] = 1'b0;
      stock_parts[s] = 0;
    end
    for (int i = 0; i < NPARTS; i++) part_done[i] = 1'b0;
    for (int unsigned r = 0; r < stock_cnt; r++) begin
      all_done = 1'b1;
      for (int unsigned i = 0; i < part_cnt; i++) if (!part_done[i]) all_done = 1'b0;
      if (all_done) break;
      for (int unsigned s = 0; s < stock_cnt; s++) begin
        best_set[s] = 0;
        best_num[s] = 0;
        best_rem[s] = 32'(lcps_pkg::NO_REMNANT);
      end
      for (int unsigned s = 0; s < stock_cnt; s++) begin
        if (stock_used[s]) continue;
        cur_set = 0;
        cur_sum = 0;
        cur_num = 0;
        fit_walk(s, 0);
      end
      win_rem = 32'(lcps_pkg::NO_REMNANT);
      win = 0;
      found = 1'b0;
      for (int unsigned s = 0; s < stock_cnt; s++) begin
        if (!stock_used[s] && best_num[s] != 0 && best_rem[s] < win_rem) begin
          win_rem = best_rem[s];
          win = s;
          found = 1'b1;
        end
      end
      if (found) begin
        stock_used[win] = 1'b1;
        stock_parts[win] = best_set[win];
        for (int unsigned i = 0; i < part_cnt; i++)
          if ((best_set[win] >> i) & 1) part_done[i] = 1'b1;
      end
    end
    // placed parts by stock, then unplaced parts, then end line
    for (int unsigned s = 0; s < stock_cnt; s++) begin
      if (!stock_used[s]) continue;
      off = 0;
      n = 0;
      for (int unsigned i = 0; i < part_cnt; i++) begin
        if (!((stock_parts[s] >> i) & 1)) continue;
        off += (n != 0 ? kerf : 0) + part_len[i];
        n++;
        line.kind = lcps_pkg::KIND_PLACED;
        line.stock = STW'(s);
        line.plen = LW'(part_len[i]);
        line.offset = LW'(off);
        line.fin = 1'b0;
        report_q.push_back(line);
      end
    end
    for (int unsigned i = 0; i < part_cnt; i++) begin
      if (part_done[i]) continue;
      line.kind = lcps_pkg::KIND_UNPLACED;
      line.stock = '0;
      line.plen = LW'(part_len[i]);
      line.offset = '0;
      line.fin = 1'b0;
      report_q.push_back(line);
    end
    line.kind = lcps_pkg::KIND_END;
    line.stock = '0;
    line.plen = '0;
    line.offset = '0;
    line.fin = 1'b1;
    report_q.push_back(line);
  endfunction

  // Shadow update for one accepted command
  function automatic void apply_cmd(logic [1:0] act, logic [LW-1:0] len);
    case (act)
      lcps_pkg::ACT_ADD_PART: begin
        if (part_cnt < NPARTS) begin
          part_len[part_cnt] = len;
          part_cnt++;
        end
      end
      lcps_pkg::ACT_ADD_STOCK: begin
        if (stock_cnt < NSTOCK) begin
          stock_len[stock_cnt] = len;
          stock_cnt++;
        end
      end
      lcps_pkg::ACT_CLEAR: begin
        part_cnt = 0;
        stock_cnt = 0;
      end
      default: plan_cuts();
    endcase
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // One command transfer; start stays high until busy is seen low.
  // Returns at the accepting edge; the next driver takes over at the
  // following falling edge.
  task automatic send_cmd(logic [1:0] act, logic [LW-1:0] len);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      action <= 2'($urandom_range(3));
      length_value <= LW'($urandom_range(16383));
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    action <= act;
    length_value <= len;
    do @(posedge clk); while (busy);
    apply_cmd(act, len);
    sent_items++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (report_q.size() != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Kerf write, only with the planner idle
  task automatic write_kerf(logic [KW-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    kerf = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= KW'($urandom_range(1023));
  endtask

  // Result checker
  always @(posedge clk) begin
    cut_line_t exp_line;
    if (!rst && result_valid) begin
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d stock=%0d len=%0d off=%0d last=%0d",
                   kind, stock_number, part_length, end_offset, last);
      end else begin
        exp_line = report_q.pop_front();
        if (kind !== exp_line.kind || stock_number !== exp_line.stock ||
            part_length !== exp_line.plen || end_offset !== exp_line.offset ||
            last !== exp_line.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     exp_line.kind, exp_line.stock, exp_line.plen, exp_line.offset,
                     exp_line.fin, kind, stock_number, part_length, end_offset, last);
        end
      end
    end
  end

  // Edge cases: empty plan, extremes, full lists, no fit, repeated plan
  task automatic test_directed();
    send_cmd(lcps_pkg::ACT_PLAN, '0);
    send_cmd(lcps_pkg::ACT_ADD_PART, '0);
    send_cmd(lcps_pkg::ACT_ADD_PART, LW'(9999));
    send_cmd(lcps_pkg::ACT_ADD_PART, LW'(5000));
    send_cmd(lcps_pkg::ACT_ADD_STOCK, LW'(9999));
    send_cmd(lcps_pkg::ACT_ADD_STOCK, '0);
    send_cmd(lcps_pkg::ACT_ADD_STOCK, LW'(5000));
    send_cmd(lcps_pkg::ACT_PLAN, LW'(16383));
    send_cmd(lcps_pkg::ACT_PLAN, '0);
    write_kerf(10'd1023);
    send_cmd(lcps_pkg::ACT_CLEAR, '0);
    send_cmd(lcps_pkg::ACT_ADD_PART, LW'(3000));
    send_cmd(lcps_pkg::ACT_ADD_PART, LW'(4000));
    send_cmd(lcps_pkg::ACT_ADD_PART, LW'(2000));
    send_cmd(lcps_pkg::ACT_ADD_STOCK, LW'(8023));
    send_cmd(lcps_pkg::ACT_ADD_STOCK, LW'(100));
    send_cmd(lcps_pkg::ACT_PLAN, '0);
    // overfull lists: no part fits the tiny stocks
    send_cmd(lcps_pkg::ACT_CLEAR, '0);
    for (int i = 0; i < NPARTS + 2; i++)
      send_cmd(lcps_pkg::ACT_ADD_PART, LW'($urandom_range(9999, 50)));
    for (int i = 0; i < NSTOCK + 2; i++)
      send_cmd(lcps_pkg::ACT_ADD_STOCK, LW'($urandom_range(20)));
    send_cmd(lcps_pkg::ACT_PLAN, '0);
    write_kerf(10'd0);
  endtask

  // Random jobs with small lists, mixed in stray commands
  task automatic test_random_jobs();
    int np;
    int ns;
    int top;
    while (sent_items < GOAL_ITEMS) begin
      if ($urandom_range(3) == 0) write_kerf($urandom_range(99) < 20 ? 10'd1023 :
                                             10'($urandom_range(300)));
      if ($urandom_range(9) != 0)
        send_cmd(lcps_pkg::ACT_CLEAR, LW'($urandom_range(16383)));
      np = $urandom_range(7);
      ns = $urandom_range(4);
      top = ($urandom_range(1)) ? 9999 : 2000;
      for (int i = 0; i < np; i++)
        send_cmd(lcps_pkg::ACT_ADD_PART,
                 ($urandom_range(15) == 0) ? '0 : LW'($urandom_range(top)));
      for (int i = 0; i < ns; i++)
        send_cmd(lcps_pkg::ACT_ADD_STOCK,
                 $urandom_range(15) == 0 ? LW'(9999) : LW'($urandom_range(9999)));
      send_cmd(lcps_pkg::ACT_PLAN, LW'($urandom_range(16383)));
      if ($urandom_range(4) == 0) send_cmd(lcps_pkg::ACT_PLAN, '0);
      // now and then hold off until the report has drained
      if ($urandom_range(5) == 0) wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = lcps_pkg::ACT_ADD_PART;
    length_value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    kerf = 0;
    part_cnt = 0;
    stock_cnt = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    wait_idle();
    test_random_jobs();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
